// ===== rtl/core/ipv4_frame_header_parser_top_defines.svh =====
// Assertion macros used by the IPv4 header parser top level.
`ifndef IPV4_FRAME_HEADER_PARSER_TOP_DEFINES_SVH
`define IPV4_FRAME_HEADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define IHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ihp_pkg.sv =====
// Types and constants for the IPv4 frame header parser.
package ihp_pkg;

  localparam logic [16:0] MAX_FRAME_BYTES  = 17'd1518;
  localparam logic [16:0] FRAME_MIN_BYTES  = 17'd34;
  localparam logic [6:0]  ETH_HDR_BYTES    = 7'd14;
  localparam logic [5:0]  IP_MIN_HDR_BYTES = 6'd20;
  localparam logic [5:0]  IP_MAX_HDR_BYTES = 6'd60;
  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [15:0] FRAG_MASK        = 16'h3FFF;
  localparam logic [15:0] ONES16           = 16'hFFFF;
  localparam logic [3:0]  IP_VERSION4      = 4'd4;

  // Frame byte offsets of captured fields
  localparam logic [15:0] POS_ETYPE_HI = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO = 16'd13;
  localparam logic [15:0] POS_VER_IHL  = 16'd14;
  localparam logic [15:0] POS_LEN_HI   = 16'd16;
  localparam logic [15:0] POS_LEN_LO   = 16'd17;
  localparam logic [15:0] POS_FRAG_HI  = 16'd20;
  localparam logic [15:0] POS_FRAG_LO  = 16'd21;
  localparam logic [15:0] POS_TTL      = 16'd22;
  localparam logic [15:0] POS_PROTO    = 16'd23;
  localparam logic [15:0] POS_SRC_FIRST = 16'd26;
  localparam logic [15:0] POS_SRC_LAST  = 16'd29;
  localparam logic [15:0] POS_DST_FIRST = 16'd30;
  localparam logic [15:0] POS_DST_LAST  = 16'd33;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_HDR   = 3'd1,
    ST_BAD_SIZE  = 3'd2,
    ST_UNSUPP    = 3'd3,
    ST_INTEGRITY = 3'd4
  } status_t;

  // Everything the final checks need from one frame
  typedef struct packed {
    logic [16:0] frame_len;
    logic [15:0] ether_type;
    logic [7:0]  version_ihl;
    logic [15:0] length_field;
    logic        frag_nz;
    logic [7:0]  ttl;
    logic [7:0]  protocol;
    logic [31:0] src;
    logic [31:0] dst;
    logic        sum_ok;
  } frame_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [5:0]  header_bytes;
    logic [15:0] total_bytes;
    logic [6:0]  payload_start;
    logic [15:0] payload_bytes;
    logic [7:0]  protocol_number;
    logic [7:0]  time_to_live;
  } result_t;

endpackage

// ===== rtl/core/ihp_if.sv =====
// Valid/ready channel interfaces for the parser's byte input and result output.
interface ihp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface ihp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] source_address;
  logic [31:0] destination_address;
  logic [5:0]  header_bytes;
  logic [15:0] total_bytes;
  logic [6:0]  payload_start;
  logic [15:0] payload_bytes;
  logic [7:0]  protocol_number;
  logic [7:0]  time_to_live;

  modport source (output valid, status, source_address, destination_address, header_bytes,
                  total_bytes, payload_start, payload_bytes, protocol_number, time_to_live,
                  input ready);
  modport sink (input valid, status, source_address, destination_address, header_bytes,
                total_bytes, payload_start, payload_bytes, protocol_number, time_to_live,
                output ready);
endinterface

// ===== rtl/core/ipv4_frame_header_parser_top.sv =====
// Top level of the Ethernet/IPv4 header parser with header checksum check.
//
// Takes one frame byte per cycle on in_ch, destination MAC first, last_byte on the final
// byte, and gives one result per frame on out_ch: status plus the IPv4 addresses, lengths,
// payload offset, protocol and TTL (all zero unless status is ok). Bytes may arrive back to
// back across frames. After the last byte's transfer the frame is registered in the snapshot
// register (capture/checksum stage), then in the output register (check stage). in_ch stalls
// only when a finished frame waits in the snapshot register while the output register is
// held by out_ch.ready low. Frames of 65536 bytes or more are reported as bad size.
`include "ipv4_frame_header_parser_top_defines.svh"

module ipv4_frame_header_parser_top import ihp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  ihp_in_if.sink   in_ch,
  ihp_out_if.source out_ch
);

  logic    snap_valid;
  frame_t  snap;
  logic    out_adv;
  logic    snap_take;
  logic    in_fire;
  logic    out_valid_r;
  result_t out_r, out_nxt;

  logic [3:0]  ver;
  logic [5:0]  hlen;
  logic [6:0]  hdr_end;
  logic [16:0] len_end;
  status_t     st;

  assign out_adv     = !out_valid_r || out_ch.ready;
  assign snap_take   = snap_valid && out_adv;
  assign in_ch.ready = !snap_valid || out_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  ihp_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .data_byte  (in_ch.data_byte),
    .last_byte  (in_ch.last_byte),
    .snap_take  (snap_take),
    .snap_valid (snap_valid),
    .snap       (snap)
  );

  // Final checks, first failing one wins
  always_comb begin
    ver     = snap.version_ihl[7:4];
    hlen    = {snap.version_ihl[3:0], 2'b00};
    hdr_end = ETH_HDR_BYTES + {1'b0, hlen};
    len_end = {1'b0, snap.length_field} + {10'd0, ETH_HDR_BYTES};

    if (snap.frame_len < FRAME_MIN_BYTES || snap.frame_len > MAX_FRAME_BYTES) begin
      st = ST_BAD_SIZE;
    end else if (snap.ether_type != ETHERTYPE_IPV4) begin
      st = ST_UNSUPP;
    end else if (ver != IP_VERSION4 || hlen < IP_MIN_HDR_BYTES || hlen > IP_MAX_HDR_BYTES ||
                 {10'd0, hdr_end} > snap.frame_len) begin
      st = ST_BAD_HDR;
    end else if (snap.length_field < {10'd0, hlen} || len_end > snap.frame_len) begin
      st = ST_BAD_SIZE;
    end else if (snap.frag_nz) begin
      st = ST_UNSUPP;
    end else if (snap.ttl == 8'd0 || !snap.sum_ok) begin
      st = ST_INTEGRITY;
    end else begin
      st = ST_OK;
    end

    out_nxt        = '0;
    out_nxt.status = st;
    if (st == ST_OK) begin
      out_nxt.source_address      = snap.src;
      out_nxt.destination_address = snap.dst;
      out_nxt.header_bytes        = hlen;
      out_nxt.total_bytes         = snap.length_field;
      out_nxt.payload_start       = hdr_end;
      out_nxt.payload_bytes       = snap.length_field - {10'd0, hlen};
      out_nxt.protocol_number     = snap.protocol;
      out_nxt.time_to_live        = snap.ttl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.status              = out_r.status;
  assign out_ch.source_address      = out_r.source_address;
  assign out_ch.destination_address = out_r.destination_address;
  assign out_ch.header_bytes        = out_r.header_bytes;
  assign out_ch.total_bytes         = out_r.total_bytes;
  assign out_ch.payload_start       = out_r.payload_start;
  assign out_ch.payload_bytes       = out_r.payload_bytes;
  assign out_ch.protocol_number     = out_r.protocol_number;
  assign out_ch.time_to_live        = out_r.time_to_live;

  `IHP_ASSERT_NEXT(a_last_fills_snap, in_fire && in_ch.last_byte, snap_valid, "last byte did not reach snapshot")
  `IHP_ASSERT_NEXT(a_take_fills_out, snap_take, out_valid_r, "snapshot transfer lost before output")
  `IHP_ASSERT_NOW(a_err_fields_zero, out_valid_r && out_r.status != ST_OK, out_r.source_address == 32'd0 && out_r.total_bytes == 16'd0 && out_r.time_to_live == 8'd0, "error result carries nonzero fields")
  `IHP_ASSERT_NOW(a_ok_offsets, out_valid_r && out_r.status == ST_OK, out_r.header_bytes >= IP_MIN_HDR_BYTES && out_r.payload_start == ETH_HDR_BYTES + {1'b0, out_r.header_bytes}, "ok result has inconsistent header offsets")

endmodule

// ===== rtl/core/ihp_accum.sv =====
// Per-byte field capture and header checksum, with a frame snapshot register.
module ihp_accum import ihp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_fire,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       snap_take,
  output logic       snap_valid,
  output frame_t     snap
);

  logic [15:0] pos_r, pos_nxt;
  logic [15:0] etype_r, etype_nxt;
  logic [7:0]  vihl_r, vihl_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] frag_r, frag_nxt;
  logic [7:0]  ttl_r, ttl_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic [15:0] csum_r, csum_nxt;
  logic [7:0]  hold_r, hold_nxt;
  logic        snap_valid_r;
  frame_t      snap_r, snap_nxt;

  logic [5:0]  hlen;
  logic [15:0] hdr_end;
  logic [16:0] sum17;
  logic [15:0] sum_fold;

  always_comb begin
    etype_nxt = etype_r;
    vihl_nxt  = vihl_r;
    len_nxt   = len_r;
    frag_nxt  = frag_r;
    ttl_nxt   = ttl_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    csum_nxt  = csum_r;
    hold_nxt  = hold_r;

    if (pos_r == POS_ETYPE_HI || pos_r == POS_ETYPE_LO) begin
      etype_nxt = {etype_r[7:0], data_byte};
    end else if (pos_r == POS_VER_IHL) begin
      vihl_nxt = data_byte;
    end else if (pos_r == POS_LEN_HI || pos_r == POS_LEN_LO) begin
      len_nxt = {len_r[7:0], data_byte};
    end else if (pos_r == POS_FRAG_HI || pos_r == POS_FRAG_LO) begin
      frag_nxt = {frag_r[7:0], data_byte};
    end else if (pos_r == POS_TTL) begin
      ttl_nxt = data_byte;
    end else if (pos_r == POS_PROTO) begin
      proto_nxt = data_byte;
    end else if (pos_r >= POS_SRC_FIRST && pos_r <= POS_SRC_LAST) begin
      src_nxt = {src_r[23:0], data_byte};
    end else if (pos_r >= POS_DST_FIRST && pos_r <= POS_DST_LAST) begin
      dst_nxt = {dst_r[23:0], data_byte};
    end

    // Header length comes from the version/IHL byte, possibly taken this transfer
    hlen     = {vihl_nxt[3:0], 2'b00};
    hdr_end  = {9'd0, ETH_HDR_BYTES} + {10'd0, hlen};
    sum17    = {1'b0, csum_r} + {1'b0, hold_r, data_byte};
    sum_fold = sum17[15:0] + {15'd0, sum17[16]};   // end-around carry

    if (pos_r >= {9'd0, ETH_HDR_BYTES} && pos_r < hdr_end) begin
      if (!pos_r[0]) begin
        hold_nxt = data_byte;
      end else begin
        csum_nxt = sum_fold;
      end
    end

    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 16'd1;

    snap_nxt.frame_len    = {1'b0, pos_r} + 17'd1;
    snap_nxt.ether_type   = etype_nxt;
    snap_nxt.version_ihl  = vihl_nxt;
    snap_nxt.length_field = len_nxt;
    snap_nxt.frag_nz      = |(frag_nxt & FRAG_MASK);
    snap_nxt.ttl          = ttl_nxt;
    snap_nxt.protocol     = proto_nxt;
    snap_nxt.src          = src_nxt;
    snap_nxt.dst          = dst_nxt;
    snap_nxt.sum_ok       = (csum_nxt == ONES16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && last_byte)) begin
      pos_r   <= '0;
      etype_r <= '0;
      vihl_r  <= '0;
      len_r   <= '0;
      frag_r  <= '0;
      ttl_r   <= '0;
      proto_r <= '0;
      src_r   <= '0;
      dst_r   <= '0;
      csum_r  <= '0;
      hold_r  <= '0;
    end else if (in_fire) begin
      pos_r   <= pos_nxt;
      etype_r <= etype_nxt;
      vihl_r  <= vihl_nxt;
      len_r   <= len_nxt;
      frag_r  <= frag_nxt;
      ttl_r   <= ttl_nxt;
      proto_r <= proto_nxt;
      src_r   <= src_nxt;
      dst_r   <= dst_nxt;
      csum_r  <= csum_nxt;
      hold_r  <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (in_fire && last_byte) begin
      snap_valid_r <= 1'b1;
    end else if (snap_take) begin
      snap_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && last_byte) begin
      snap_r <= snap_nxt;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap       = snap_r;

endmodule
